FILE: hw/rtl/rfrb_pkg.sv
// Package: constants, types and register indexes for the row FIR filter.
`timescale 1ns / 1ps
`default_nettype none

package rfrb_pkg;

    localparam int MAX_ORDER     = 3;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int COEF_WIDTH    = 18;
    localparam int FRAC_SHIFT    = 16;
    localparam int ORDER_WIDTH   = 2;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int NUM_COEF_REGS = 4;

    localparam int WIN_DEPTH   = 2 * MAX_ORDER + 1;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int FILL_WIDTH  = $clog2(WIN_DEPTH + 1);
    localparam int HALF_DEPTH  = MAX_ORDER + 1;
    localparam int PROD_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH + 1;
    localparam int ACC_WIDTH   = PROD_WIDTH + $clog2(WIN_DEPTH);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ORDER,
        REG_SYMMETRY,
        REG_COEF0,
        REG_COEF1,
        REG_COEF2,
        REG_COEF3
    } reg_idx_t;

    typedef logic signed [SAMPLE_WIDTH-1:0] pix_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef pix_t  [WIN_DEPTH-1:0]          win_t;
    typedef coef_t [HALF_DEPTH-1:0]         coef_arr_t;

    typedef struct packed {
        logic [ORDER_WIDTH-1:0] order;
        logic                   symmetric;
        coef_arr_t              half_coef;
    } cfg_t;

    typedef struct packed {
        logic                   last;
        logic [ORDER_WIDTH-1:0] order;
        win_t                   win;
    } tap_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rfrb_cfg.sv
// Configuration registers and effective filter order.
`timescale 1ns / 1ps
`default_nettype none

module rfrb_cfg
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rfrb_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [rfrb_pkg::COEF_WIDTH-1:0]     cfg_data,
    output rfrb_pkg::cfg_t                           cfg
);
    import rfrb_pkg::*;

    logic [ORDER_WIDTH-1:0] order_reg;
    logic                   sym_reg;
    coef_arr_t              coef_reg;
    logic                   wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_WIDTH'(1);
            sym_reg   <= 1'b1;
            for (int h = 0; h < HALF_DEPTH; h++)
            begin
                coef_reg[h] <= (h == 0) ? coef_t'(1 << FRAC_SHIFT) : coef_t'(0);
            end
        end
        else if (wr_en)
        begin
            if (cfg_index == REG_ORDER)
            begin
                order_reg <= cfg_data[ORDER_WIDTH-1:0];
            end
            if (cfg_index == REG_SYMMETRY)
            begin
                sym_reg <= cfg_data[0];
            end
            for (int h = 0; h < HALF_DEPTH; h++)
            begin
                if (h < NUM_COEF_REGS &&
                    {1'b0, cfg_index} == (CFG_IDX_WIDTH + 1)'(REG_COEF0 + h))
                begin
                    coef_reg[h] <= coef_t'(cfg_data);
                end
            end
        end
    end

    always_comb
    begin
        cfg.symmetric = sym_reg;
        cfg.half_coef = coef_reg;
        if (order_reg == '0)
        begin
            cfg.order = ORDER_WIDTH'(1);
        end
        else if (int'(order_reg) > MAX_ORDER)
        begin
            cfg.order = ORDER_WIDTH'(MAX_ORDER);
        end
        else
        begin
            cfg.order = order_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rfrb_window.sv
// Pixel window with border replication and row-end flush sequencing.
`timescale 1ns / 1ps
`default_nettype none

module rfrb_window
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [rfrb_pkg::SAMPLE_WIDTH-1:0] pixel_in,
    input  wire logic                            row_end,
    input  wire logic [rfrb_pkg::ORDER_WIDTH-1:0]  order,
    input  wire logic                            req_ready,
    output logic                                 req_valid,
    output rfrb_pkg::tap_req_t                   req
);
    import rfrb_pkg::*;

    typedef enum logic {
        ST_PIXEL,
        ST_FLUSH
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    win_t                   win_reg;
    win_t                   win_next;
    logic [FILL_WIDTH-1:0]  fill_reg;
    logic [FILL_WIDTH-1:0]  fill_next;
    logic [FILL_WIDTH-1:0]  fill_inc;
    logic [ORDER_WIDTH-1:0] flush_reg;
    logic [ORDER_WIDTH-1:0] flush_next;
    logic                   pix_step;
    logic                   flush_step;
    logic                   emit;
    logic                   last;

    assign in_stall   = (state_reg == ST_FLUSH) | ~req_ready;
    assign pix_step   = in_valid & ~in_stall;
    assign flush_step = (state_reg == ST_FLUSH) & req_ready;
    assign fill_inc   = (int'(fill_reg) < WIN_DEPTH) ? fill_reg + FILL_WIDTH'(1) : fill_reg;

    always_comb
    begin
        win_next   = win_reg;
        fill_next  = fill_reg;
        flush_next = flush_reg;
        state_next = state_reg;
        emit       = 1'b0;
        last       = 1'b0;
        if (pix_step)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                if (fill_reg == '0 || i == WIN_DEPTH - 1)
                begin
                    win_next[i] = pix_t'(pixel_in);
                end
                else
                begin
                    win_next[i] = win_reg[i+1];
                end
            end
            fill_next = fill_inc;
            emit      = {1'b0, fill_inc} > (FILL_WIDTH + 1)'(order);
            if (row_end)
            begin
                state_next = ST_FLUSH;
                flush_next = ORDER_WIDTH'(1);
            end
        end
        else if (flush_step)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WIN_DEPTH-1] = win_reg[WIN_DEPTH-1];
            emit = ({1'b0, fill_reg} + (FILL_WIDTH + 1)'(flush_reg))
                   > (FILL_WIDTH + 1)'(order);
            last = (flush_reg == order);
            if (last)
            begin
                state_next = ST_PIXEL;
                fill_next  = '0;
                flush_next = '0;
            end
            else
            begin
                flush_next = flush_reg + ORDER_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PIXEL;
            fill_reg  <= '0;
            flush_reg <= '0;
            win_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            flush_reg <= flush_next;
            win_reg   <= win_next;
        end
    end

    assign req_valid = emit;
    assign req.last  = last;
    assign req.order = order;
    assign req.win   = win_next;

endmodule

`default_nettype wire

FILE: hw/rtl/rfrb_mac.sv
// Tap products stage and accumulation stage.
`timescale 1ns / 1ps
`default_nettype none

module rfrb_mac
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rfrb_pkg::cfg_t                     cfg,
    input  wire logic                               req_valid,
    input  wire rfrb_pkg::tap_req_t                 req,
    output logic                                    req_ready,
    input  wire logic                               sum_ready,
    output logic                                    sum_valid,
    output logic signed [rfrb_pkg::ACC_WIDTH-1:0]   sum,
    output logic                                    sum_last
);
    import rfrb_pkg::*;

    logic signed [PROD_WIDTH-1:0] prod_reg [WIN_DEPTH];
    logic signed [PROD_WIDTH-1:0] prod_next [WIN_DEPTH];
    logic                         prod_valid_reg;
    logic                         prod_last_reg;
    logic signed [ACC_WIDTH-1:0]  sum_reg;
    logic signed [ACC_WIDTH-1:0]  sum_next;
    logic                         sum_valid_reg;
    logic                         sum_last_reg;
    logic                         sum_load;

    assign sum_load  = ~sum_valid_reg | sum_ready;
    assign req_ready = ~prod_valid_reg | sum_load;

    always_comb
    begin
        int                    d;
        int                    ad;
        logic [WIN_IDX_W-1:0]  idx;
        logic signed [PROD_WIDTH-1:0] p;
        for (int t = 0; t < WIN_DEPTH; t++)
        begin
            d   = t - MAX_ORDER;
            ad  = (d < 0) ? -d : d;
            idx = WIN_IDX_W'(WIN_DEPTH - 1 + d) - WIN_IDX_W'(req.order);
            p   = $signed(cfg.half_coef[ad]) * $signed(req.win[idx]);
            if (ad > int'(req.order))
            begin
                prod_next[t] = '0;
            end
            else if (!cfg.symmetric && d >= 0)
            begin
                prod_next[t] = -p;
            end
            else
            begin
                prod_next[t] = p;
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int t = 0; t < WIN_DEPTH; t++)
        begin
            sum_next = sum_next + ACC_WIDTH'(prod_reg[t]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                prod_valid_reg <= req_valid;
            end
            if (sum_load)
            begin
                sum_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready)
        begin
            prod_last_reg <= req.last;
            for (int t = 0; t < WIN_DEPTH; t++)
            begin
                prod_reg[t] <= prod_next[t];
            end
        end
        if (sum_load)
        begin
            sum_reg      <= sum_next;
            sum_last_reg <= prod_last_reg;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;
    assign sum_last  = sum_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/row_fir_replicate_border.sv
// Top level: row FIR filter with replicated borders, rounding and output register.
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | pixel_in, row_end
// out     | output    | out_valid/out_stall| filtered_pixel, row_last
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pixel per cycle unless stalled; results pass product, sum and output registers.
// A pixel with row_end adds as many flush steps as the kernel order, input stalled.
// Reset loads the identity filter (order 1, symmetric, center tap 1.0).
// out_stall holds the output register and backs up through the product and sum stages.
`timescale 1ns / 1ps
`default_nettype none

module row_fir_replicate_border
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [rfrb_pkg::SAMPLE_WIDTH-1:0] pixel_in,
    input  wire logic                                row_end,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [rfrb_pkg::SAMPLE_WIDTH-1:0] filtered_pixel,
    output logic                                     row_last,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rfrb_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [rfrb_pkg::COEF_WIDTH-1:0]     cfg_data
);
    import rfrb_pkg::*;

    localparam logic signed [ACC_WIDTH-1:0] SAT_HI = ACC_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -ACC_WIDTH'(1 << (SAMPLE_WIDTH - 1));
    localparam logic signed [ACC_WIDTH-1:0] RND    = ACC_WIDTH'(1 << (FRAC_SHIFT - 1));

    cfg_t                        cfg;
    tap_req_t                    req;
    logic                        req_valid;
    logic                        req_ready;
    logic                        sum_valid;
    logic signed [ACC_WIDTH-1:0] sum;
    logic                        sum_last;
    logic                        out_load;
    logic signed [ACC_WIDTH-1:0] rounded;
    logic signed [ACC_WIDTH-1:0] quot;
    pix_t                        sat;
    logic                        out_valid_reg;
    pix_t                        pix_reg;
    logic                        last_reg;

    rfrb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfrb_window u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_in  (pixel_in),
        .row_end   (row_end),
        .order     (cfg.order),
        .req_ready (req_ready),
        .req_valid (req_valid),
        .req       (req)
    );

    rfrb_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .sum_ready (out_load),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_last  (sum_last)
    );

    assign out_load = ~out_valid_reg | ~out_stall;
    assign rounded  = sum + RND;
    assign quot     = rounded >>> FRAC_SHIFT;

    always_comb
    begin
        priority if (quot > SAT_HI)
        begin
            sat = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (quot < SAT_LO)
        begin
            sat = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            sat = quot[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pix_reg  <= sat;
            last_reg <= sum_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_pixel = pix_reg;
    assign row_last       = last_reg;

endmodule

`default_nettype wire
